// ===== hdl/wis_pkg.sv =====
// ----------------------------------------------------------------------------
// wis_pkg
// Shared constants and controller/datapath interface types for the
// weighted id selector.
// ----------------------------------------------------------------------------
package wis_pkg;

  // table size and derived widths
  localparam int MAX_CANDIDATES = 16;
  localparam int IDX_W   = $clog2(MAX_CANDIDATES);
  localparam int PTR_W   = $clog2(MAX_CANDIDATES + 1);
  localparam int RAW_W   = $clog2(MAX_CANDIDATES + 2);
  localparam int ID_W    = 8;
  localparam int WT_W    = 8;
  localparam int TOTAL_W = WT_W + IDX_W;
  localparam int RND_W   = 32;
  localparam int DCNT_W  = $clog2(RND_W);

  localparam logic [WT_W-1:0]   WEIGHT_MAX = {WT_W{1'b1}};
  localparam logic [RAW_W-1:0]  RAW_LIMIT  = RAW_W'(MAX_CANDIDATES);
  localparam logic [PTR_W-1:0]  TABLE_FULL = PTR_W'(MAX_CANDIDATES);
  localparam logic [DCNT_W-1:0] DCNT_LAST  = DCNT_W'(RND_W - 1);

  // result status codes
  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_TOO_MANY   = 2'd1,
    STATUS_ZERO_TOTAL = 2'd2
  } status_t;

  // commands from controller to datapath
  typedef struct packed {
    logic    load;
    logic    adv;
    logic    merge;
    logic    ins_start;
    logic    shift_step;
    logic    ins_write;
    logic    rd_prev;
    logic    sum_init;
    logic    sum_step;
    logic    div_init;
    logic    div_step;
    logic    walk_step;
    logic    finish;
    status_t fin_status;
  } wis_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic ins_en;
    logic last;
    logic too_many;
    logic at_end;
    logic id_lt;
    logic id_eq;
    logic full;
    logic at_pos;
    logic acc_zero;
    logic div_last;
    logic hit;
  } wis_sts_t;

endpackage

// ===== hdl/weighted_id_selector_unit.sv =====
// ----------------------------------------------------------------------------
// weighted_id_selector_unit
// Roulette-wheel selection over a streamed list of (id, weight) candidates.
// ----------------------------------------------------------------------------
// One candidate is taken per transaction (start high while busy is low). A
// candidate with nonzero weight, among the first 16 of its list, is searched
// for in a table kept sorted by id, one entry per cycle, then merged or, if
// the table is not full, inserted by shifting the tail up one entry per
// cycle. For the candidate with last_cand set, a list of more than 16
// candidates ends with status too-many; otherwise the unit then sums the
// table, reports a zero total as such, and else reduces random_value modulo
// the total with a bit-serial remainder unit and walks the cumulative weights.
// The result appears on chosen_id and select_status when done is high for a
// single cycle, which cannot be held off, and stays there until the next
// result; nothing is reported for other candidates.
// ----------------------------------------------------------------------------
module weighted_id_selector_unit
  import wis_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic [ID_W-1:0]  cand_id,
  input  logic [WT_W-1:0]  cand_weight,
  input  logic             last_cand,
  input  logic [RND_W-1:0] random_value,
  output logic             done,
  output logic [ID_W-1:0]  chosen_id,
  output logic [1:0]       select_status
);

  wis_cmd_t cmd;
  wis_sts_t sts;
  status_t  status_q;

  // controller
  wis_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  // datapath
  wis_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .cand_id       (cand_id),
    .cand_weight   (cand_weight),
    .last_cand     (last_cand),
    .random_value  (random_value),
    .sts           (sts),
    .chosen_id     (chosen_id),
    .select_status (status_q)
  );

  assign select_status = status_q;

`ifndef SYNTH
  // a failed selection never reports an id
  a_fail_zero_id: assert property (@(posedge clk) disable iff (rst)
    done && (select_status != STATUS_OK) |-> chosen_id == '0)
    else $error("nonzero id reported with failure status");

  // result strobe lasts one cycle
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held longer than one cycle");

  // an accepted transaction always makes the unit busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("unit not busy after accepting a transaction");

  // a result only follows work in progress
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(done) |-> $past(busy))
    else $error("result strobe without a transaction in progress");
`endif

endmodule

// ===== hdl/wis_dp.sv =====
// ----------------------------------------------------------------------------
// wis_dp
// Datapath: sorted id/weight table, counters, weight accumulator, bit-serial
// remainder unit and cumulative walk, all stepped by controller commands.
// ----------------------------------------------------------------------------
module wis_dp
  import wis_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  wis_cmd_t         cmd,
  input  logic [ID_W-1:0]  cand_id,
  input  logic [WT_W-1:0]  cand_weight,
  input  logic             last_cand,
  input  logic [RND_W-1:0] random_value,
  output wis_sts_t         sts,
  output logic [ID_W-1:0]  chosen_id,
  output status_t          select_status
);

  // table storage, one read and one write address per cycle
  logic [ID_W-1:0] ids [MAX_CANDIDATES];
  logic [WT_W-1:0] wts [MAX_CANDIDATES];

  // captured transaction
  logic [ID_W-1:0]  cid;
  logic [WT_W-1:0]  cwt;
  logic             last;
  logic [RND_W-1:0] rnd;
  logic             ins_en;

  // counters and work registers
  logic [RAW_W-1:0]   raw;
  logic [PTR_W-1:0]   count;
  logic [PTR_W-1:0]   ptr;
  logic [PTR_W-1:0]   pos;
  logic [TOTAL_W-1:0] acc;
  logic [TOTAL_W-1:0] rem;
  logic [DCNT_W-1:0]  dcnt;

  logic [RAW_W-1:0]   raw_next;
  logic [PTR_W-1:0]   rd_ptr;
  logic [IDX_W-1:0]   rd_idx;
  logic [IDX_W-1:0]   wr_idx;
  logic [ID_W-1:0]    id_rd;
  logic [WT_W-1:0]    wt_rd;
  logic [WT_W:0]      wt_sum;
  logic [WT_W-1:0]    wt_sat;
  logic [TOTAL_W:0]   rem_sh;
  logic [TOTAL_W-1:0] rem_div;
  logic [TOTAL_W-1:0] wt_ext;

  // table read port: previous entry while shifting, current otherwise
  assign rd_ptr = cmd.rd_prev ? ptr - PTR_W'(1) : ptr;
  assign rd_idx = rd_ptr[IDX_W-1:0];
  assign wr_idx = ptr[IDX_W-1:0];
  assign id_rd  = ids[rd_idx];
  assign wt_rd  = wts[rd_idx];
  assign wt_ext = TOTAL_W'(wt_rd);

  // saturating weight merge for a repeated id
  assign wt_sum = {1'b0, wt_rd} + {1'b0, cwt};
  assign wt_sat = wt_sum[WT_W] ? WEIGHT_MAX : wt_sum[WT_W-1:0];

  // one restoring remainder step
  assign rem_sh  = {rem, rnd[RND_W-1]};
  assign rem_div = (rem_sh >= {1'b0, acc}) ? TOTAL_W'(rem_sh - {1'b0, acc})
                                           : rem_sh[TOTAL_W-1:0];

  // raw candidate count saturates one above the limit
  assign raw_next = (raw <= RAW_LIMIT) ? raw + RAW_W'(1) : raw;

  // status toward the controller
  assign sts.ins_en   = ins_en;
  assign sts.last     = last;
  assign sts.too_many = raw > RAW_LIMIT;
  assign sts.at_end   = ptr == count;
  assign sts.id_lt    = id_rd < cid;
  assign sts.id_eq    = id_rd == cid;
  assign sts.full     = count >= TABLE_FULL;
  assign sts.at_pos   = ptr == pos;
  assign sts.acc_zero = acc == '0;
  assign sts.div_last = dcnt == DCNT_LAST;
  assign sts.hit      = rem < wt_ext;

  // table writes
  always_ff @(posedge clk) begin
    if (cmd.merge) begin
      wts[wr_idx] <= wt_sat;
    end else if (cmd.shift_step) begin
      ids[wr_idx] <= id_rd;
      wts[wr_idx] <= wt_rd;
    end else if (cmd.ins_write) begin
      ids[wr_idx] <= cid;
      wts[wr_idx] <= cwt;
    end
  end

  // transaction capture and work registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cid    <= cand_id;
      cwt    <= cand_weight;
      last   <= last_cand;
      rnd    <= random_value;
      ins_en <= (raw_next <= RAW_LIMIT) && (cand_weight != '0);
    end else if (cmd.div_step) begin
      rnd <= {rnd[RND_W-2:0], 1'b0};
    end

    if (cmd.load || cmd.sum_init || cmd.div_init) begin
      ptr <= '0;
    end else if (cmd.adv || cmd.walk_step || cmd.sum_step) begin
      ptr <= ptr + PTR_W'(1);
    end else if (cmd.ins_start) begin
      ptr <= count;
    end else if (cmd.shift_step) begin
      ptr <= ptr - PTR_W'(1);
    end

    if (cmd.ins_start) begin
      pos <= ptr;
    end

    if (cmd.sum_init) begin
      acc <= '0;
    end else if (cmd.sum_step) begin
      acc <= acc + wt_ext;
    end

    if (cmd.div_init) begin
      rem  <= '0;
      dcnt <= '0;
    end else if (cmd.div_step) begin
      rem  <= rem_div;
      dcnt <= dcnt + DCNT_W'(1);
    end else if (cmd.walk_step) begin
      rem <= rem - wt_ext;
    end

    if (cmd.finish) begin
      select_status <= cmd.fin_status;
      chosen_id     <= (cmd.fin_status == STATUS_OK && sts.hit) ? id_rd : '0;
    end
  end

  // list counters, cleared after every list
  always_ff @(posedge clk) begin
    if (rst || cmd.finish) begin
      raw   <= '0;
      count <= '0;
    end else begin
      if (cmd.load) begin
        raw <= raw_next;
      end
      if (cmd.ins_write) begin
        count <= count + PTR_W'(1);
      end
    end
  end

endmodule

// ===== hdl/wis_ctrl.sv =====
// ----------------------------------------------------------------------------
// wis_ctrl
// Controller: sequences table search, insertion shift, weight sum,
// remainder iterations and the cumulative walk.
// ----------------------------------------------------------------------------
module wis_ctrl
  import wis_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  wis_sts_t sts,
  output wis_cmd_t cmd,
  output logic     busy,
  output logic     done
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_FIN,
    S_SUM,
    S_DIV,
    S_WALK
  } state_t;

  state_t state;
  state_t state_next;

  assign busy = state != S_IDLE;

  // next state and command decode
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.fin_status = STATUS_OK;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!sts.ins_en) begin
          state_next = S_FIN;
        end else if (!sts.at_end && sts.id_eq) begin
          cmd.merge  = 1'b1;
          state_next = S_FIN;
        end else if (!sts.at_end && sts.id_lt) begin
          cmd.adv = 1'b1;
        end else if (sts.full) begin
          state_next = S_FIN;
        end else begin
          cmd.ins_start = 1'b1;
          state_next    = S_SHIFT;
        end
      end
      S_SHIFT: begin
        if (sts.at_pos) begin
          cmd.ins_write = 1'b1;
          state_next    = S_FIN;
        end else begin
          cmd.rd_prev    = 1'b1;
          cmd.shift_step = 1'b1;
        end
      end
      S_FIN: begin
        if (!sts.last) begin
          state_next = S_IDLE;
        end else if (sts.too_many) begin
          cmd.finish     = 1'b1;
          cmd.fin_status = STATUS_TOO_MANY;
          state_next     = S_IDLE;
        end else begin
          cmd.sum_init = 1'b1;
          state_next   = S_SUM;
        end
      end
      S_SUM: begin
        if (!sts.at_end) begin
          cmd.sum_step = 1'b1;
        end else if (sts.acc_zero) begin
          cmd.finish     = 1'b1;
          cmd.fin_status = STATUS_ZERO_TOTAL;
          state_next     = S_IDLE;
        end else begin
          cmd.div_init = 1'b1;
          state_next   = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = S_WALK;
        end
      end
      S_WALK: begin
        if (sts.hit || sts.at_end) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end else begin
          cmd.walk_step = 1'b1;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state and result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= cmd.finish;
    end
  end

endmodule
